// File: rtl/command_grammar_dfa_top_assert.svh
// Assertion macros used by the command grammar checker back end.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef COMMAND_GRAMMAR_DFA_TOP_ASSERT_SVH
`define COMMAND_GRAMMAR_DFA_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("command grammar check failed");

// The consequent must hold in the cycle after the antecedent.
`define CGD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("command grammar check failed");

`endif

// File: rtl/cgd_pkg.sv
package cgd_pkg;

  // Token classes as delivered by the upstream word lookup.
  localparam logic [4:0] CLS_NAME     = 5'd0;
  localparam logic [4:0] CLS_SELECT   = 5'd1;
  localparam logic [4:0] CLS_ASTERISK = 5'd2;
  localparam logic [4:0] CLS_COMMA    = 5'd3;
  localparam logic [4:0] CLS_FROM     = 5'd4;
  localparam logic [4:0] CLS_WHERE    = 5'd5;
  localparam logic [4:0] CLS_COMPARE  = 5'd6;
  localparam logic [4:0] CLS_AND      = 5'd7;
  localparam logic [4:0] CLS_OR       = 5'd8;
  localparam logic [4:0] CLS_PRINT    = 5'd9;
  localparam logic [4:0] CLS_DROP     = 5'd10;
  localparam logic [4:0] CLS_STORE    = 5'd11;
  localparam logic [4:0] CLS_LOAD     = 5'd12;
  localparam logic [4:0] CLS_CREATE   = 5'd13;
  localparam logic [4:0] CLS_TABLE    = 5'd14;
  localparam logic [4:0] CLS_INT      = 5'd15;
  localparam logic [4:0] CLS_FLOAT    = 5'd16;
  localparam logic [4:0] CLS_STRING   = 5'd17;
  localparam logic [4:0] CLS_INSERT   = 5'd18;
  localparam logic [4:0] CLS_INTO     = 5'd19;
  localparam logic [4:0] CLS_VALUES   = 5'd20;
  localparam logic [4:0] CLS_CLS      = 5'd21;
  localparam logic [4:0] CLS_HELP     = 5'd22;

  // Token roles reported with each result.
  localparam logic [2:0] ROLE_OTHER    = 3'd0;
  localparam logic [2:0] ROLE_COMMAND  = 3'd1;
  localparam logic [2:0] ROLE_COMPARE  = 3'd2;
  localparam logic [2:0] ROLE_AND      = 3'd3;
  localparam logic [2:0] ROLE_OR       = 3'd4;
  localparam logic [2:0] ROLE_WHERE    = 3'd5;
  localparam logic [2:0] ROLE_ASTERISK = 3'd6;
  localparam logic [2:0] ROLE_COMMA    = 3'd7;

  // Grammar states.
  localparam logic [5:0] ST_IDLE      = 6'd0;
  localparam logic [5:0] ST_SEL       = 6'd1;
  localparam logic [5:0] ST_SEL_STAR  = 6'd2;
  localparam logic [5:0] ST_FROM      = 6'd3;
  localparam logic [5:0] ST_TBL_NAME  = 6'd4;
  localparam logic [5:0] ST_PRINT     = 6'd5;
  localparam logic [5:0] ST_DROP      = 6'd6;
  localparam logic [5:0] ST_STORE     = 6'd7;
  localparam logic [5:0] ST_LOAD      = 6'd8;
  localparam logic [5:0] ST_FIELD     = 6'd9;
  localparam logic [5:0] ST_FIELD_SEP = 6'd10;
  localparam logic [5:0] ST_WHERE     = 6'd11;
  localparam logic [5:0] ST_COND_LHS  = 6'd12;
  localparam logic [5:0] ST_COND_OP   = 6'd13;
  localparam logic [5:0] ST_COND_RHS  = 6'd14;
  localparam logic [5:0] ST_CONJ      = 6'd15;
  localparam logic [5:0] ST_INSERT    = 6'd16;
  localparam logic [5:0] ST_INTO      = 6'd18;
  localparam logic [5:0] ST_INS_TBL   = 6'd20;
  localparam logic [5:0] ST_VALUES    = 6'd21;
  localparam logic [5:0] ST_VALUE     = 6'd22;
  localparam logic [5:0] ST_VALUE_SEP = 6'd23;
  localparam logic [5:0] ST_CREATE    = 6'd24;
  localparam logic [5:0] ST_CRT_TBL   = 6'd26;
  localparam logic [5:0] ST_COL_START = 6'd28;
  localparam logic [5:0] ST_COL_NAME  = 6'd30;
  localparam logic [5:0] ST_COL_TYPE  = 6'd32;
  localparam logic [5:0] ST_CLS       = 6'd40;
  localparam logic [5:0] ST_HELP      = 6'd41;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic [4:0]  cls;
    logic [15:0] tag;
    logic        first;
    logic        last;
    logic [2:0]  role;
    logic        is_where;
    logic        is_star;
  } cgd_word_t;

  // One result word.
  typedef struct packed {
    logic [5:0]  new_state;
    logic        dead;
    logic [2:0]  role;
    logic [15:0] tag_out;
    logic        ignored;
    logic        done_res;
    logic        accept;
    logic        select_all;
    logic        has_where;
  } cgd_result_t;

  // Outcome of one table step.
  typedef struct packed {
    logic       ok;
    logic [5:0] nxt;
  } cgd_move_t;

  // Transition table of the grammar.
  function automatic cgd_move_t next_move(input logic [5:0] st, input logic [4:0] cls);
    cgd_move_t mv;
    mv.ok  = 1'b1;
    mv.nxt = ST_IDLE;
    unique case (st) inside
      ST_IDLE: begin
        unique case (cls)
          CLS_SELECT: mv.nxt = ST_SEL;
          CLS_PRINT:  mv.nxt = ST_PRINT;
          CLS_DROP:   mv.nxt = ST_DROP;
          CLS_STORE:  mv.nxt = ST_STORE;
          CLS_LOAD:   mv.nxt = ST_LOAD;
          CLS_CREATE: mv.nxt = ST_CREATE;
          CLS_INSERT: mv.nxt = ST_INSERT;
          CLS_CLS:    mv.nxt = ST_CLS;
          CLS_HELP:   mv.nxt = ST_HELP;
          default:    mv.ok  = 1'b0;
        endcase
      end
      ST_SEL: begin
        if (cls == CLS_NAME) mv.nxt = ST_FIELD;
        else if (cls == CLS_ASTERISK) mv.nxt = ST_SEL_STAR;
        else mv.ok = 1'b0;
      end
      ST_FIELD: begin
        if (cls == CLS_COMMA) mv.nxt = ST_FIELD_SEP;
        else if (cls == CLS_FROM) mv.nxt = ST_FROM;
        else mv.ok = 1'b0;
      end
      ST_FIELD_SEP: begin
        if (cls == CLS_NAME) mv.nxt = ST_FIELD;
        else mv.ok = 1'b0;
      end
      ST_SEL_STAR: begin
        if (cls == CLS_FROM) mv.nxt = ST_FROM;
        else mv.ok = 1'b0;
      end
      ST_FROM: begin
        if (cls == CLS_NAME) mv.nxt = ST_TBL_NAME;
        else mv.ok = 1'b0;
      end
      ST_TBL_NAME: begin
        if (cls == CLS_COMMA) mv.nxt = ST_FROM;
        else if (cls == CLS_WHERE) mv.nxt = ST_WHERE;
        else mv.ok = 1'b0;
      end
      ST_WHERE, ST_CONJ: begin
        if (cls == CLS_NAME) mv.nxt = ST_COND_LHS;
        else mv.ok = 1'b0;
      end
      ST_COND_LHS: begin
        if (cls == CLS_COMPARE) mv.nxt = ST_COND_OP;
        else mv.ok = 1'b0;
      end
      ST_COND_OP: begin
        if (cls == CLS_NAME) mv.nxt = ST_COND_RHS;
        else mv.ok = 1'b0;
      end
      ST_COND_RHS: begin
        if (cls == CLS_AND || cls == CLS_OR) mv.nxt = ST_CONJ;
        else mv.ok = 1'b0;
      end
      ST_PRINT, ST_DROP, ST_STORE, ST_LOAD: begin
        if (cls == CLS_NAME) mv.nxt = ST_TBL_NAME;
        else mv.ok = 1'b0;
      end
      ST_CREATE: begin
        if (cls == CLS_TABLE) mv.nxt = ST_CRT_TBL;
        else mv.ok = 1'b0;
      end
      ST_CRT_TBL: begin
        if (cls == CLS_NAME) mv.nxt = ST_COL_START;
        else mv.ok = 1'b0;
      end
      ST_COL_START: begin
        if (cls == CLS_NAME) mv.nxt = ST_COL_NAME;
        else mv.ok = 1'b0;
      end
      ST_COL_NAME: begin
        if (cls == CLS_INT || cls == CLS_FLOAT || cls == CLS_STRING) mv.nxt = ST_COL_TYPE;
        else mv.ok = 1'b0;
      end
      ST_COL_TYPE: begin
        if (cls == CLS_COMMA) mv.nxt = ST_COL_START;
        else mv.ok = 1'b0;
      end
      ST_INSERT: begin
        if (cls == CLS_INTO) mv.nxt = ST_INTO;
        else mv.ok = 1'b0;
      end
      ST_INTO: begin
        if (cls == CLS_NAME) mv.nxt = ST_INS_TBL;
        else mv.ok = 1'b0;
      end
      ST_INS_TBL: begin
        if (cls == CLS_VALUES) mv.nxt = ST_VALUES;
        else mv.ok = 1'b0;
      end
      ST_VALUES, ST_VALUE_SEP: begin
        if (cls == CLS_NAME) mv.nxt = ST_VALUE;
        else mv.ok = 1'b0;
      end
      ST_VALUE: begin
        if (cls == CLS_COMMA) mv.nxt = ST_VALUE_SEP;
        else mv.ok = 1'b0;
      end
      default: mv.ok = 1'b0;
    endcase
    return mv;
  endfunction

  // Role of a token class; unknown classes count as other.
  function automatic logic [2:0] role_of(input logic [4:0] cls);
    logic [2:0] role;
    unique case (cls) inside
      CLS_SELECT, CLS_PRINT, CLS_DROP, CLS_STORE, CLS_LOAD, CLS_CREATE, CLS_INSERT,
      CLS_HELP:     role = ROLE_COMMAND;
      CLS_COMPARE:  role = ROLE_COMPARE;
      CLS_AND:      role = ROLE_AND;
      CLS_OR:       role = ROLE_OR;
      CLS_WHERE:    role = ROLE_WHERE;
      CLS_ASTERISK: role = ROLE_ASTERISK;
      CLS_COMMA:    role = ROLE_COMMA;
      default:      role = ROLE_OTHER;
    endcase
    return role;
  endfunction

  // States in which a command may end.
  function automatic logic is_accepting(input logic [5:0] st);
    return st == ST_TBL_NAME || st == ST_COND_RHS || st == ST_VALUE ||
           st == ST_COL_TYPE || st == ST_CLS || st == ST_HELP;
  endfunction

endpackage

// File: rtl/command_grammar_dfa_top.sv
// Channel  | Direction | Handshake                | Word
// ---------+-----------+--------------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o  | token_class, token_tag, first, last
// out      | output    | out_valid_o / out_stall_i| new_state, dead, role, tag_out, ignored,
//          |           |                          | done_res, accept, select_all, has_where
//
// One word per cycle in and out while out_stall_i is low; an accepted token passes the
// front register, the queue and the result register in that order.
// The rate is set by the back end's combinational table step, whose grammar state feeds back.
// Reset is asynchronous and clears the valid flags, the queue count and the grammar state.
// A two-word queue parts classification from the grammar step, so an output stall
// reaches in_stall_o only once the queue and the front register are both full.
module command_grammar_dfa_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  token_class_i,
  input  logic [15:0] token_tag_i,
  input  logic        first_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  new_state_o,
  output logic        dead_o,
  output logic [2:0]  role_o,
  output logic [15:0] tag_out_o,
  output logic        ignored_o,
  output logic        done_res_o,
  output logic        accept_o,
  output logic        select_all_o,
  output logic        has_where_o
);

  cgd_pkg::cgd_word_t   front_word, head_word;
  cgd_pkg::cgd_result_t res;
  logic                 push, full, pop, empty;

  // Front end: accepts and classifies tokens.
  cgd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .token_class_i (token_class_i),
    .token_tag_i   (token_tag_i),
    .first_i       (first_i),
    .last_i        (last_i),
    .push_o        (push),
    .word_o        (front_word),
    .full_i        (full)
  );

  // Queue between the two ends.
  cgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_word),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_word),
    .empty_o (empty)
  );

  // Back end: walks the grammar and registers the result.
  cgd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  assign new_state_o  = res.new_state;
  assign dead_o       = res.dead;
  assign role_o       = res.role;
  assign tag_out_o    = res.tag_out;
  assign ignored_o    = res.ignored;
  assign done_res_o   = res.done_res;
  assign accept_o     = res.accept;
  assign select_all_o = res.select_all;
  assign has_where_o  = res.has_where;

endmodule

// File: rtl/cgd_front.sv
module cgd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [4:0]          token_class_i,
  input  logic [15:0]         token_tag_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                push_o,
  output cgd_pkg::cgd_word_t  word_o,
  input  logic                full_i
);

  logic               valid_q, valid_d;
  cgd_pkg::cgd_word_t word_q, word_d;
  logic               take;

  // The input stalls only while a held word cannot move into the queue.
  assign in_stall_o = valid_q && full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign push_o     = valid_q;
  assign word_o     = word_q;

  // Classify the incoming token and track occupancy of the front register.
  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (valid_q && !full_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d         = 1'b1;
      word_d.cls      = token_class_i;
      word_d.tag      = token_tag_i;
      word_d.first    = first_i;
      word_d.last     = last_i;
      word_d.role     = cgd_pkg::role_of(token_class_i);
      word_d.is_where = token_class_i == cgd_pkg::CLS_WHERE;
      word_d.is_star  = token_class_i == cgd_pkg::CLS_ASTERISK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// File: rtl/cgd_fifo.sv
module cgd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cgd_pkg::cgd_word_t  wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output cgd_pkg::cgd_word_t  rdata_o,
  output logic                empty_o
);

  cgd_pkg::cgd_word_t               mem_q [cgd_pkg::QUEUE_DEPTH];
  logic [cgd_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cgd_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cgd_pkg::QCNT_W-1:0]       count_q, count_d;
  logic                             do_push, do_pop;

  localparam logic [cgd_pkg::QPTR_W-1:0] PtrLast = cgd_pkg::QPTR_W'(cgd_pkg::QUEUE_DEPTH - 1);
  localparam logic [cgd_pkg::QCNT_W-1:0] CntFull = cgd_pkg::QCNT_W'(cgd_pkg::QUEUE_DEPTH);

  assign full_o  = count_q == CntFull;
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/cgd_back.sv
`include "command_grammar_dfa_top_assert.svh"

module cgd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  cgd_pkg::cgd_word_t   head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cgd_pkg::cgd_result_t res_o
);

  logic [5:0]           cur_q, cur_d;
  logic                 failed_q, failed_d;
  logic                 where_q, where_d;
  logic                 all_q, all_d;
  logic                 out_valid_q;
  cgd_pkg::cgd_result_t res_q, res_d;
  logic                 load;

  logic [5:0]           st_in, st_nx;
  logic                 failed_in, where_in, all_in;
  logic                 failed_nx, where_nx, all_nx;
  cgd_pkg::cgd_move_t   mv;

  // A word leaves the queue whenever the output register is free or draining.
  assign load        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  // One grammar step on the word at the head of the queue.
  always_comb begin
    st_in     = head_i.first ? cgd_pkg::ST_IDLE : cur_q;
    failed_in = head_i.first ? 1'b0 : failed_q;
    where_in  = head_i.first ? 1'b0 : where_q;
    all_in    = head_i.first ? 1'b0 : all_q;
    mv        = cgd_pkg::next_move(st_in, head_i.cls);

    st_nx     = st_in;
    failed_nx = failed_in;
    where_nx  = where_in;
    all_nx    = all_in;

    res_d           = res_q;
    res_d.new_state = cgd_pkg::ST_IDLE;
    res_d.dead      = 1'b1;
    res_d.role      = cgd_pkg::ROLE_OTHER;
    res_d.tag_out   = head_i.tag;
    res_d.ignored   = 1'b0;
    res_d.done_res  = head_i.last;

    if (failed_in) begin
      res_d.ignored = 1'b1;
    end else begin
      res_d.role = head_i.role;
      where_nx   = where_in || head_i.is_where;
      all_nx     = all_in || head_i.is_star;
      if (!mv.ok) begin
        failed_nx = 1'b1;
      end else begin
        st_nx           = mv.nxt;
        res_d.new_state = mv.nxt;
        res_d.dead      = 1'b0;
      end
    end

    res_d.accept     = head_i.last && !failed_nx && cgd_pkg::is_accepting(st_nx);
    res_d.select_all = head_i.last && all_nx;
    res_d.has_where  = head_i.last && where_nx;

    // The end of a command returns everything to the start.
    cur_d    = cur_q;
    failed_d = failed_q;
    where_d  = where_q;
    all_d    = all_q;
    if (load) begin
      if (head_i.last) begin
        cur_d    = cgd_pkg::ST_IDLE;
        failed_d = 1'b0;
        where_d  = 1'b0;
        all_d    = 1'b0;
      end else begin
        cur_d    = st_nx;
        failed_d = failed_nx;
        where_d  = where_nx;
        all_d    = all_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= cgd_pkg::ST_IDLE;
      failed_q    <= 1'b0;
      where_q     <= 1'b0;
      all_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q    <= cur_d;
      failed_q <= failed_d;
      where_q  <= where_d;
      all_q    <= all_d;
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  // Result register needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  `CGD_ASSERT_NOW(a_dead_state_zero, out_valid_q && res_q.dead,
                  res_q.new_state == cgd_pkg::ST_IDLE)
  `CGD_ASSERT_NOW(a_ignored_quiet, out_valid_q && res_q.ignored,
                  res_q.dead && res_q.role == cgd_pkg::ROLE_OTHER)
  `CGD_ASSERT_NOW(a_accept_on_done, out_valid_q && res_q.accept,
                  res_q.done_res && !res_q.dead)
  `CGD_ASSERT_NEXT(a_last_clears, load && head_i.last,
                   cur_q == cgd_pkg::ST_IDLE && !failed_q && !where_q && !all_q)
  `CGD_ASSERT_NEXT(a_fail_sticks, load && failed_q && !head_i.first && !head_i.last,
                   failed_q)

endmodule
